// ===== hw/rtl/sam_pkg.sv =====
// Shared constants, payload types and controller/datapath link types for the sector map.
package sam_pkg;

   localparam int DEF_SECTORS      = 10;
   localparam int MAX_SECTORS_DEF  = 64;
   localparam int SECTOR_BYTES_DEF = 512;
   localparam int ID_BITS_DEF      = 16;

   localparam int KIND_W     = 3;
   localparam int BYTES_W    = 16;
   localparam int FIELD_ID_W = 16;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEFRAG  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [BYTES_W-1:0]    byte_count;
      logic [FIELD_ID_W-1:0] file_id;
      logic [IDX_W-1:0]      sector_index;
   } req_type;

   typedef struct packed {
      logic [FIELD_ID_W-1:0] new_id;
      logic [CNT_W-1:0]      free_sectors;
      logic [FIELD_ID_W-1:0] sector_owner;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic wipe;
      logic res_commit;
      logic scan_init;
      logic scan_step;
      logic rd_issue;
      logic sort_init;
      logic sort_take;
      logic sort_shift;
      logic sort_put;
      logic resp;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              res_ok;
      logic              scan_done;
      logic              sort_done;
      logic              shift;
      logic              j_one;
   } sts_type;

   // usable map depth: bounded by the 7-bit sector count
   function automatic int map_depth(input int max_sectors);
      int lim;
      lim = (1 << CNT_W) - 1;
      return (max_sectors < lim) ? max_sectors : lim;
   endfunction

   function automatic logic [CNT_W-1:0] fit_size(input logic [CNT_W-1:0] v, input int depth);
      logic [CNT_W-1:0] r;
      r = (v == '0) ? CNT_W'(DEF_SECTORS) : v;
      if (int'(r) > depth) r = CNT_W'(depth);
      return r;
   endfunction

endpackage

// ===== hw/rtl/sam_csr.sv =====
// Configuration register: disk sector count, with map wipe on write.
module sam_csr #(
   parameter int MAX_SECTORS = sam_pkg::MAX_SECTORS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sam_pkg::CSR_AW-1:0]  paddr,
   input  logic [sam_pkg::CSR_DW-1:0]  pwdata,
   output logic [sam_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output logic                        cfg_wr,
   output logic [sam_pkg::CNT_W-1:0]   cfg_size,
   output logic [sam_pkg::CNT_W-1:0]   sectors
);
   import sam_pkg::*;

   localparam int DEPTH = map_depth(MAX_SECTORS);
   localparam logic [CNT_W-1:0] RST_SIZE = fit_size(CNT_W'(DEF_SECTORS), DEPTH);

   logic [CNT_W-1:0] sectors_ff;

   // register 0 answers at offsets 0 to 3; paddr[2] set means beyond the list
   assign cfg_wr   = psel & penable & pwrite & ~paddr[2];
   assign cfg_size = fit_size(pwdata[CNT_W-1:0], DEPTH);
   assign pready   = 1'b1;
   assign sectors  = sectors_ff;
   assign prdata   = paddr[2] ? '0 : CSR_DW'(sectors_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff <= RST_SIZE;
      end else if (cfg_wr) begin
         sectors_ff <= cfg_size;
      end
   end

endmodule

// ===== hw/rtl/sam_ctrl.sv =====
// Sequencer for the sector map: decodes a request and steps the datapath.
module sam_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output sam_pkg::cmd_type cmd,
   input  sam_pkg::sts_type sts
);
   import sam_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_SCAN      = 3'd2;
   localparam logic [2:0] S_SORT_NEXT = 3'd3;
   localparam logic [2:0] S_SORT_TAKE = 3'd4;
   localparam logic [2:0] S_SORT_CMP  = 3'd5;
   localparam logic [2:0] S_SORT_PUT  = 3'd6;
   localparam logic [2:0] S_RESP      = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.kind)
               KIND_RESERVE: begin
                  if (sts.res_ok) begin
                     cmd.res_commit = 1'b1;
                     cmd.scan_init  = 1'b1;
                     state_in       = S_SCAN;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               KIND_CANCEL: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
               KIND_DEFRAG: begin
                  cmd.sort_init = 1'b1;
                  state_in      = S_SORT_NEXT;
               end
               KIND_CLEAR: begin
                  cmd.wipe = 1'b1;
                  state_in = S_RESP;
               end
               KIND_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_RESP;
         end
         S_SORT_NEXT: begin
            if (sts.sort_done) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SORT_TAKE;
            end
         end
         S_SORT_TAKE: begin
            cmd.sort_take = 1'b1;
            state_in      = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (sts.shift) begin
               cmd.sort_shift = 1'b1;
               if (sts.j_one) state_in = S_SORT_PUT;
            end else begin
               cmd.sort_put = 1'b1;
               state_in     = S_SORT_NEXT;
            end
         end
         S_SORT_PUT: begin
            cmd.sort_put = 1'b1;
            state_in     = S_SORT_NEXT;
         end
         S_RESP: begin
            cmd.resp = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/sam_dpath.sv =====
// Sector map datapath: owner memory with valid bits, scan and sort registers, result beat.
module sam_dpath #(
   parameter int MAX_SECTORS  = sam_pkg::MAX_SECTORS_DEF,
   parameter int SECTOR_BYTES = sam_pkg::SECTOR_BYTES_DEF,
   parameter int ID_BITS      = sam_pkg::ID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sam_pkg::req_type          req_data,
   input  sam_pkg::cmd_type          cmd,
   output sam_pkg::sts_type          sts,
   input  logic                      cfg_wr,
   input  logic [sam_pkg::CNT_W-1:0] cfg_size,
   input  logic [sam_pkg::CNT_W-1:0] sectors,
   output logic                      rsp_strobe,
   output sam_pkg::rsp_type          rsp_data
);
   import sam_pkg::*;

   localparam int DEPTH = map_depth(MAX_SECTORS);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SBW   = $clog2(SECTOR_BYTES + 1);
   localparam int PW    = CNT_W + SBW;
   localparam int CW    = (PW > BYTES_W) ? PW : BYTES_W;
   localparam int ACC_W = $clog2((1 << BYTES_W) + SECTOR_BYTES);
   localparam int IDC_W = (ID_BITS > FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
   localparam logic [CNT_W-1:0]   RST_SIZE = fit_size(CNT_W'(DEF_SECTORS), DEPTH);
   localparam logic [ID_BITS-1:0] ID_MAX   = '1;

   logic [ID_BITS-1:0]    mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [ID_BITS-1:0]    rd_data_ff;
   logic                  rd_valid_ff;

   req_type               req_ff;
   logic [CNT_W-1:0]      free_ff;
   logic [ID_BITS-1:0]    last_id_ff;
   logic [FIELD_ID_W-1:0] nid_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      j_ff;
   logic [ID_BITS-1:0]    v_ff;
   logic                  pv_ff;
   logic [AW-1:0]         pa_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   logic [ID_BITS-1:0]    entry;
   logic [IDC_W-1:0]      entry_ext;
   logic [IDC_W-1:0]      fid_ext;
   logic [ID_BITS-1:0]    id_next;
   logic [IDC_W-1:0]      id_next_ext;
   logic [CNT_W-1:0]      rd_idx;
   logic [CNT_W-1:0]      idx_m1;
   logic [CNT_W-1:0]      j_m2;
   logic                  rd_hit;
   logic                  issue;
   logic [CW-1:0]         room;
   logic                  res_put;
   logic                  can_put;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ID_BITS-1:0]    wr_data;

   // a sector never written since the last wipe reads as free
   assign entry       = rd_valid_ff ? rd_data_ff : '0;
   assign entry_ext   = IDC_W'(entry);
   assign fid_ext     = IDC_W'(req_ff.file_id);
   assign id_next     = last_id_ff + ID_BITS'(1);
   assign id_next_ext = IDC_W'(id_next);
   assign rd_idx      = CNT_W'(req_ff.sector_index);
   assign rd_hit      = (rd_idx < sectors);
   assign idx_m1      = idx_ff - CNT_W'(1);
   assign j_m2        = j_ff - CNT_W'(2);
   assign issue       = (idx_ff < sectors);

   // enough room iff free * sector size covers the byte count
   assign room = CW'(free_ff) * CW'(SECTOR_BYTES);

   assign res_put = pv_ff && (req_ff.kind == KIND_RESERVE) && (entry == '0)
                    && (acc_ff < ACC_W'(req_ff.byte_count));
   assign can_put = pv_ff && (req_ff.kind == KIND_CANCEL) && (req_ff.file_id != '0)
                    && (entry_ext == fid_ext);

   assign sts.kind      = req_ff.kind;
   assign sts.res_ok    = (room >= CW'(req_ff.byte_count)) && (last_id_ff != ID_MAX);
   assign sts.scan_done = !issue && !pv_ff;
   assign sts.sort_done = !issue;
   assign sts.shift     = (entry < v_ff);
   assign sts.j_one     = (j_ff == CNT_W'(1));

   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      if (cmd.rd_issue) rd_addr = rd_idx[AW-1:0];
      else if (cmd.sort_take) rd_addr = idx_m1[AW-1:0];
      else if (cmd.sort_shift) rd_addr = j_m2[AW-1:0];
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pa_ff;
      wr_data = '0;
      if (res_put) begin
         wr_en   = 1'b1;
         wr_data = last_id_ff;
      end else if (can_put) begin
         wr_en   = 1'b1;
      end else if (cmd.sort_shift) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[AW-1:0];
         wr_data = entry;
      end else if (cmd.sort_put) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[AW-1:0];
         wr_data = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr || cmd.wipe) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         free_ff       <= RST_SIZE;
         last_id_ff    <= '0;
         pv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= valid_ff[rd_addr];
         rsp_strobe_ff <= cmd.resp;
         if (cfg_wr) begin
            free_ff    <= cfg_size;
            last_id_ff <= '0;
         end else if (cmd.wipe) begin
            free_ff    <= sectors;
            last_id_ff <= '0;
         end else begin
            if (cmd.res_commit) last_id_ff <= id_next;
            if (res_put) free_ff <= free_ff - CNT_W'(1);
            else if (can_put) free_ff <= free_ff + CNT_W'(1);
         end
         if (cmd.scan_init) pv_ff <= 1'b0;
         else if (cmd.scan_step) pv_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.load) nid_ff <= '0;
      else if (cmd.res_commit) nid_ff <= id_next_ext[FIELD_ID_W-1:0];
      if (cmd.scan_init) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.scan_step) begin
         pa_ff <= idx_ff[AW-1:0];
         if (issue) idx_ff <= idx_ff + CNT_W'(1);
         if (res_put) acc_ff <= acc_ff + ACC_W'(SECTOR_BYTES);
      end else if (cmd.sort_init) begin
         idx_ff <= CNT_W'(1);
      end else if (cmd.sort_take) begin
         v_ff <= entry;
         j_ff <= idx_ff;
      end else if (cmd.sort_shift) begin
         j_ff <= j_ff - CNT_W'(1);
      end else if (cmd.sort_put) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.resp) begin
         rsp_ff.new_id       <= nid_ff;
         rsp_ff.free_sectors <= free_ff;
         rsp_ff.sector_owner <= ((req_ff.kind == KIND_READ) && rd_hit)
                                ? entry_ext[FIELD_ID_W-1:0] : '0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hw/rtl/sector_allocation_map_unit.sv =====
// Sector allocation map: top level joining register port, sequencer and datapath.
// A request is taken when start is high and busy is low; exactly one result beat follows,
// shown on rsp_data for the single cycle that rsp_strobe is high, and it cannot be held off.
// Read, clear and unrecognised kinds go from decode straight to the result beat; reserve
// and cancel first scan every sector in use, as the owner memory has one read port and the
// scan visits one sector a cycle; a failed reserve skips the scan. Defragment is an insertion
// sort through that same port: each entry is taken, the smaller entries before it are shifted
// up one place, and it is put into the gap. busy falls on the cycle the result beat is shown.
// Reset and writes of sectors_in_use wipe the map at once through per-sector valid bits:
// there is no clearing pass.
module sector_allocation_map_unit #(
   parameter int MAX_SECTORS  = sam_pkg::MAX_SECTORS_DEF,
   parameter int SECTOR_BYTES = sam_pkg::SECTOR_BYTES_DEF,
   parameter int ID_BITS      = sam_pkg::ID_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  sam_pkg::req_type           req_data,
   output logic                       rsp_strobe,
   output sam_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sam_pkg::CSR_AW-1:0] paddr,
   input  logic [sam_pkg::CSR_DW-1:0] pwdata,
   output logic [sam_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import sam_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic             cfg_wr;
   logic [CNT_W-1:0] cfg_size;
   logic [CNT_W-1:0] sectors;

   sam_csr #(
      .MAX_SECTORS (MAX_SECTORS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg_wr   (cfg_wr),
      .cfg_size (cfg_size),
      .sectors  (sectors)
   );

   sam_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   sam_dpath #(
      .MAX_SECTORS  (MAX_SECTORS),
      .SECTOR_BYTES (SECTOR_BYTES),
      .ID_BITS      (ID_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .cfg_wr     (cfg_wr),
      .cfg_size   (cfg_size),
      .sectors    (sectors),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
